// ===== design/lpfr_pkg.sv =====
// Package for the length-prefixed frame receiver.
// Holds register map codes, reset values and input opcodes.
// No dependencies.
package lpfr_pkg;

    // Register map, one 32-bit word per register
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_START_BYTE    = 2'd0,
        REG_MIN_FRAME_LEN = 2'd1,
        REG_MAX_FRAME_LEN = 2'd2,
        REG_TIMEOUT_TICKS = 2'd3
    } cfg_reg_t;

    // Register reset values
    localparam logic [7:0]  START_BYTE_RST    = 8'd50;
    localparam logic [8:0]  MIN_FRAME_LEN_RST = 9'd4;
    localparam logic [8:0]  MAX_FRAME_LEN_RST = 9'd256;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd500;

    // Largest frame total the fill counter supports
    localparam int MAX_FRAME_DEF = 256;

    // Input item kinds
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

endpackage

// ===== design/length_prefixed_frame_receiver_core.sv =====
// Length-prefixed frame receiver: start-byte hunt, length check, timeout.
// Top level with APB-style register port. Depends on lpfr_pkg.
//
// Latency: an accepted transfer's result is registered in the output register in the cycle after it is accepted.
// Throughput: one input transfer per cycle; s_ready drops only while a result waits
// in the output register and m_ready is low.
// Reset (aresetn, synchronous, active low): registers return to their defaults,
// the receiver goes back to hunting for the start byte and the output is emptied.
module length_prefixed_frame_receiver_core #(
    parameter int MAX_FRAME = lpfr_pkg::MAX_FRAME_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_opcode,
    input  logic [7:0]                      s_rx_byte,
    // Result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_data_byte,
    output logic [7:0]                      m_byte_index,
    output logic                            m_frame_end,
    output logic                            m_frame_drop,
    // Register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lpfr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lpfr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lpfr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import lpfr_pkg::*;

    // Fill counter holds 0 .. MAX_FRAME
    localparam int FW = $clog2(MAX_FRAME + 1);

    // Configuration registers
    logic [7:0]  start_byte_reg;
    logic [8:0]  min_len_reg;
    logic [8:0]  max_len_reg;
    logic [15:0] timeout_reg;

    // Frame state
    logic [FW-1:0] fill_reg,     fill_next;
    logic [FW-1:0] exp_reg,      exp_next;
    logic [7:0]    len_high_reg, len_high_next;
    logic [15:0]   idle_reg,     idle_next;

    // Output register
    logic       m_valid_reg;
    logic [7:0] data_reg,  data_next;
    logic [7:0] index_reg, index_next;
    logic       end_reg,   end_next;
    logic       drop_reg,  drop_next;
    logic       res_valid;

    logic        s_fire;
    logic        cfg_wr;
    logic [16:0] total;
    logic [15:0] idle_inc;
    logic [FW-1:0] fill_inc;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= START_BYTE_RST;
            min_len_reg    <= MIN_FRAME_LEN_RST;
            max_len_reg    <= MAX_FRAME_LEN_RST;
            timeout_reg    <= TIMEOUT_TICKS_RST;
        end else if (cfg_wr) begin
            case (cfg_reg_t'(paddr[3:2]))
                REG_START_BYTE:    start_byte_reg <= pwdata[7:0];
                REG_MIN_FRAME_LEN: min_len_reg    <= pwdata[8:0];
                REG_MAX_FRAME_LEN: max_len_reg    <= pwdata[8:0];
                REG_TIMEOUT_TICKS: timeout_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (cfg_reg_t'(paddr[3:2]))
            REG_START_BYTE:    prdata = {24'd0, start_byte_reg};
            REG_MIN_FRAME_LEN: prdata = {23'd0, min_len_reg};
            REG_MAX_FRAME_LEN: prdata = {23'd0, max_len_reg};
            REG_TIMEOUT_TICKS: prdata = {16'd0, timeout_reg};
            default:           prdata = '0;
        endcase
    end

    // Handshake: take a new transfer whenever the output slot is free or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    assign total    = {1'b0, len_high_reg, s_rx_byte} + 17'd2;
    assign idle_inc = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign fill_inc = fill_reg + FW'(1);

    // Per-item frame logic
    always_comb begin
        fill_next     = fill_reg;
        exp_next      = exp_reg;
        len_high_next = len_high_reg;
        idle_next     = idle_reg;
        res_valid     = 1'b0;
        data_next     = s_rx_byte;
        index_next    = 8'(fill_reg);
        end_next      = 1'b0;
        drop_next     = 1'b0;

        if (opcode_t'(s_opcode) == OP_TICK) begin
            // Tick: count idle time only inside a frame
            if (fill_reg != '0) begin
                idle_next = idle_inc;
                if ({1'b0, idle_inc} > {1'b0, timeout_reg}) begin
                    fill_next     = '0;
                    exp_next      = '0;
                    len_high_next = '0;
                    idle_next     = '0;
                    res_valid     = 1'b1;
                    data_next     = '0;
                    index_next    = '0;
                    drop_next     = 1'b1;
                end
            end
        end else begin
            idle_next = '0;
            if (fill_reg == '0) begin
                // Hunting for the start byte
                if (s_rx_byte == start_byte_reg) begin
                    fill_next = FW'(1);
                    res_valid = 1'b1;
                end
            end else if (fill_reg == FW'(1)) begin
                // Length high byte
                len_high_next = s_rx_byte;
                fill_next     = FW'(2);
                res_valid     = 1'b1;
            end else if (fill_reg == FW'(2)) begin
                // Length low byte: check the frame total
                res_valid = 1'b1;
                if (total < 17'd3 || total < {8'd0, min_len_reg}
                    || total > {8'd0, max_len_reg} || total > 17'(MAX_FRAME)) begin
                    fill_next     = '0;
                    exp_next      = '0;
                    len_high_next = '0;
                    data_next     = '0;
                    index_next    = '0;
                    drop_next     = 1'b1;
                end else if (total == 17'd3) begin
                    fill_next     = '0;
                    exp_next      = '0;
                    len_high_next = '0;
                    end_next      = 1'b1;
                end else begin
                    exp_next  = FW'(total);
                    fill_next = FW'(3);
                end
            end else begin
                // Frame body
                res_valid = 1'b1;
                fill_next = fill_inc;
                if (fill_inc >= exp_reg) begin
                    fill_next     = '0;
                    exp_next      = '0;
                    len_high_next = '0;
                    end_next      = 1'b1;
                end
            end
        end
    end

    // Frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            exp_reg      <= '0;
            len_high_reg <= '0;
            idle_reg     <= '0;
        end else if (s_fire) begin
            fill_reg     <= fill_next;
            exp_reg      <= exp_next;
            len_high_reg <= len_high_next;
            idle_reg     <= idle_next;
        end
    end

    // Output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= res_valid;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (s_fire && res_valid) begin
            data_reg  <= data_next;
            index_reg <= index_next;
            end_reg   <= end_next;
            drop_reg  <= drop_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_data_byte  = data_reg;
    assign m_byte_index = index_reg;
    assign m_frame_end  = end_reg;
    assign m_frame_drop = drop_reg;

    // Checks
    a_end_drop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_frame_end && m_frame_drop))
        else $error("frame end and drop in one result");

    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_drop |-> m_data_byte == 8'd0 && m_byte_index == 8'd0)
        else $error("drop result carries data");

    a_close_rehunt: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && res_valid && (end_next || drop_next) |=> fill_reg == '0)
        else $error("frame closed but receiver not hunting");

    a_body_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg >= FW'(3) |-> fill_reg < exp_reg)
        else $error("fill count past expected total");

endmodule

// ===== test/tb.sv =====
// Testbench for length_prefixed_frame_receiver_core: start-byte hunt, length check,
// byte forwarding and tick timeout, checked against a cycle-free predictor.
// Depends on lpfr_pkg and the core; self-contained otherwise.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpfr_pkg::*;

    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic       frame_end;
        logic       frame_drop;
    } frame_out_t;

    // Tracks the receiver state, predicts each transfer's result and checks the outputs
    class frame_checker;
        logic [7:0]  start_byte;
        logic [8:0]  min_len;
        logic [8:0]  max_len;
        logic [15:0] timeout;
        logic [8:0]  fill;
        logic [8:0]  total;
        logic [7:0]  len_hi;
        logic [15:0] idle;
        frame_out_t  pending_out[$];
        int          errors;
        int          result_count;
        int          frame_items;

        function new();
            start_byte = START_BYTE_RST;
            min_len    = MIN_FRAME_LEN_RST;
            max_len    = MAX_FRAME_LEN_RST;
            timeout    = TIMEOUT_TICKS_RST;
            restart_hunt();
        endfunction

        function void restart_hunt();
            fill   = '0;
            total  = '0;
            len_hi = '0;
            idle   = '0;
        endfunction

        function void push_out(logic [7:0] d, logic [7:0] idx, logic fe, logic fd);
            frame_out_t o;
            o = '{d, idx, fe, fd};
            pending_out.push_back(o);
        endfunction

        function void set_register(cfg_reg_t r, logic [31:0] v);
            case (r)
                REG_START_BYTE:    start_byte = v[7:0];
                REG_MIN_FRAME_LEN: min_len    = v[8:0];
                REG_MAX_FRAME_LEN: max_len    = v[8:0];
                REG_TIMEOUT_TICKS: timeout    = v[15:0];
                default: ;
            endcase
        endfunction

        // Predict the result of one accepted input transfer
        function void note_item(opcode_t op, logic [7:0] b);
            logic [16:0] sum;
            logic [8:0]  idx;
            if (op == OP_TICK) begin
                if (fill == 0) return;
                frame_items++;
                if (idle != 16'hFFFF) idle++;
                if (idle > timeout) begin
                    restart_hunt();
                    push_out(8'h00, 8'h00, 1'b0, 1'b1);
                end
                return;
            end
            idle = '0;
            if (fill == 0) begin
                if (b != start_byte) return;
                frame_items++;
                fill = 9'd1;
                push_out(b, 8'd0, 1'b0, 1'b0);
                return;
            end
            frame_items++;
            if (fill == 1) begin
                len_hi = b;
                fill = 9'd2;
                push_out(b, 8'd1, 1'b0, 1'b0);
            end else if (fill == 2) begin
                sum = {len_hi, b} + 17'd2;
                if (sum < 3 || sum < min_len || sum > max_len || sum > MAX_FRAME_DEF) begin
                    restart_hunt();
                    push_out(8'h00, 8'h00, 1'b0, 1'b1);
                end else if (sum == 3) begin
                    restart_hunt();
                    push_out(b, 8'd2, 1'b1, 1'b0);
                end else begin
                    total = sum[8:0];
                    fill = 9'd3;
                    push_out(b, 8'd2, 1'b0, 1'b0);
                end
            end else begin
                idx = fill;
                fill++;
                if (fill >= total) begin
                    restart_hunt();
                    push_out(b, idx[7:0], 1'b1, 1'b0);
                end else begin
                    push_out(b, idx[7:0], 1'b0, 1'b0);
                end
            end
        endfunction

        // Compare one output transfer with the oldest prediction
        function void check_out(frame_out_t got);
            frame_out_t want;
            result_count++;
            if (pending_out.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %0d unexpected: data %h idx %0d end %b drop %b",
                             result_count, got.data_byte, got.byte_index, got.frame_end,
                             got.frame_drop);
                return;
            end
            want = pending_out.pop_front();
            if (got.data_byte !== want.data_byte || got.byte_index !== want.byte_index ||
                got.frame_end !== want.frame_end || got.frame_drop !== want.frame_drop) begin
                errors++;
                if (errors <= 10)
                    $display(
                        "ERROR: result %0d exp/act: data %h/%h idx %0d/%0d end %b/%b drop %b/%b",
                        result_count, want.data_byte, got.data_byte, want.byte_index,
                        got.byte_index, want.frame_end, got.frame_end, want.frame_drop,
                        got.frame_drop);
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    opcode_t               s_opcode = OP_BYTE;
    logic [7:0]            s_rx_byte = 8'h00;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [7:0]            m_data_byte;
    logic [7:0]            m_byte_index;
    logic                  m_frame_end;
    logic                  m_frame_drop;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    frame_checker chk;
    frame_out_t   seen;
    int           gap_pct = 0;
    int           stall_pct = 0;
    int           hold_req = 0;
    int           hold_left = 0;
    int           quiet_cycles = 0;

    length_prefixed_frame_receiver_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data_byte  (m_data_byte),
        .m_byte_index (m_byte_index),
        .m_frame_end  (m_frame_end),
        .m_frame_drop (m_frame_drop),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Result side: random stalls, plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Transfer monitor; results are checked before the same edge's input is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen = '{m_data_byte, m_byte_index, m_frame_end, m_frame_drop};
                chk.check_out(seen);
            end
            if (s_valid && s_ready)
                chk.note_item(s_opcode, s_rx_byte);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_item(opcode_t op, logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < gap_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(OP_BYTE, b);
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_item(OP_TICK, 8'($urandom_range(255)));
    endtask

    // Header plus body bytes; short ticks runs stay within the timeout
    task automatic send_frame(logic [15:0] len, int body);
        int cap;
        send_byte(chk.start_byte);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        repeat (body) begin
            cap = (chk.timeout < 3) ? int'(chk.timeout) : 3;
            if (cap > 0 && $urandom_range(4) == 0)
                send_ticks($urandom_range(1, cap));
            send_byte(8'($urandom_range(255)));
        end
    endtask

    // Stop offering and wait until every predicted result has been seen
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (chk.pending_out.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(cfg_reg_t r, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        chk.set_register(r, v);
        @(posedge aclk);
    endtask

    task automatic configure(logic [7:0] sb, logic [8:0] mn, logic [8:0] mx, logic [15:0] to,
                             int gap, int stall);
        wait_drained();
        write_register(REG_START_BYTE, 32'(sb));
        write_register(REG_MIN_FRAME_LEN, 32'(mn));
        write_register(REG_MAX_FRAME_LEN, 32'(mx));
        write_register(REG_TIMEOUT_TICKS, 32'(to));
        gap_pct   = gap;
        stall_pct = stall;
    endtask

    // One random chunk: mostly well-formed frames, some broken ones and noise
    task automatic random_burst();
        int pick;
        int len;
        int tot;
        int body;
        int cap;
        bit ok;
        pick = $urandom_range(99);
        cap  = (chk.timeout < 6) ? int'(chk.timeout) + 2 : 8;
        if (pick < 70) begin
            pick = $urandom_range(99);
            if (pick < 80)
                len = $urandom_range(0, 22);
            else if (pick < 92)
                len = $urandom_range(0, 300);
            else
                len = $urandom_range(65535);
            tot  = len + 2;
            ok   = tot >= 3 && tot >= chk.min_len && tot <= chk.max_len && tot <= MAX_FRAME_DEF;
            body = ok ? len - 1 : 0;
            if (body > 0 && $urandom_range(9) == 0) begin
                // truncated frame, left to time out where the timeout is short
                send_frame(16'(len), $urandom_range(body - 1));
                if (chk.timeout <= 8)
                    send_ticks(chk.timeout + 1);
            end else begin
                send_frame(16'(len), body);
            end
        end else if (pick < 85) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
        end else if (pick < 95) begin
            send_ticks($urandom_range(1, cap));
        end else begin
            send_byte(chk.start_byte);
            repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(255)));
            send_ticks($urandom_range(0, cap));
        end
    endtask

    task automatic run_items(int n);
        int goal;
        goal = chk.frame_items + n;
        while (chk.frame_items < goal) random_burst();
    endtask

    initial begin
        chk = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed checks at reset register values
        send_byte(8'h00);
        send_byte(8'hFF);
        send_ticks(1);              // hunting: all ignored
        send_frame(16'd2, 1);       // smallest legal total
        send_frame(16'd0, 0);       // total below three
        send_frame(16'd256, 0);     // total above max_frame_len
        send_frame(16'hFFFF, 0);    // largest length field
        send_frame(16'd3, 1);       // open frame, tick inside, then completed
        send_ticks(1);
        send_byte(8'h00);

        // Moderate limits, short timeout, no idling
        configure(8'($urandom_range(255)), 9'd4, 9'd64, 16'd5, 0, 0);
        run_items(150);

        // Three-byte frames allowed, timeout zero, sender mostly idle
        configure(8'h00, 9'd3, 9'd20, 16'd0, 82, 0);
        send_frame(16'd1, 0);
        run_items(120);

        // Widest limits, longest timeout, receiver mostly stalled
        configure(8'hFF, 9'd0, 9'd511, 16'hFFFF, 0, 82);
        send_frame(16'd254, 253);   // full-size frame, index up to 255
        send_frame(16'd255, 0);     // allowed by register, over the frame buffer
        run_items(150);

        // min above max rejects everything; light idling on both sides
        configure(8'($urandom_range(255)), 9'd511, 9'd4, 16'd7, 7, 7);
        run_items(60);
        send_byte(chk.start_byte);  // frame stays open across the register change
        send_byte(8'h00);

        // Receiver holds off while the sender keeps pushing
        configure(8'hA5, 9'd4, 9'd256, 16'd3, 0, 0);
        run_items(40);
        hold_req = 300;
        run_items(60);
        wait_drained();
        run_items(80);

        wait_drained();
        if (chk.errors == 0 && chk.pending_out.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
